[hdl/mrcd_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the reply checker.
`default_nettype none

package mrcd_pkg;

  // Default number of bytes kept per frame; later bytes are ignored.
  localparam int FRAME_CAPACITY_DEF = 128;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes that the decoder understands.
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

  // Byte counts of a read reply.
  localparam logic [7:0] BC_ONE_WORD = 8'd2;
  localparam logic [7:0] BC_TWO_WORD = 8'd4;

  // Bit pattern of the float -9999.0, reported for unsupported codes.
  localparam logic [31:0] UNSUPPORTED_WORD = 32'hC61C3C00;

  // Shortest frame that carries a CRC.
  localparam logic [7:0] MIN_FRAME_LEN = 8'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [1:0] ST_CRC_ERR   = 2'd2;

  // Decode kinds.
  localparam logic [1:0] KIND_WORD16 = 2'd0;
  localparam logic [1:0] KIND_WORD32 = 2'd1;
  localparam logic [1:0] KIND_UNSUPP = 2'd2;
  localparam logic [1:0] KIND_KEEP   = 2'd3;

  // One received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } mrcd_in_t;

  // One result of a finished frame.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fn_code;
    logic [1:0]  decode_kind;
    logic [31:0] value;
    logic [7:0]  frame_length;
  } mrcd_out_t;

  // Frame summary handed from the frame tracker to the decoder.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] fn_code;
    logic [7:0] byte_cnt_field;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] length;
  } mrcd_frame_sum_t;

  // One byte of CRC-16/MODBUS, bit by bit (reflected).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/mrcd_frame_track.sv]
// Per-frame state: CRC accumulator, two-byte tail delay, byte count and header bytes.
`default_nettype none

module mrcd_frame_track
  import mrcd_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last,
  output mrcd_frame_sum_t      summary
);

  logic [15:0] crc_acc;
  logic [15:0] crc_acc_next;
  logic [7:0]  tail_delay [2];
  logic [7:0]  tail_delay_next [2];
  logic [7:0]  kept_len;
  logic [7:0]  kept_len_next;
  logic [7:0]  header_bytes [6];
  logic [7:0]  header_bytes_next [6];
  logic        keep;
  logic [15:0] rx_crc;

  // Update of the frame state by one byte; bytes beyond capacity are dropped.
  always_comb begin
    keep = kept_len < 8'(FRAME_CAPACITY);
    crc_acc_next = crc_acc;
    tail_delay_next = tail_delay;
    kept_len_next = kept_len;
    header_bytes_next = header_bytes;
    if (keep) begin
      if (kept_len >= 8'd2) begin
        crc_acc_next = crc_byte(crc_acc, tail_delay[0]);
      end
      tail_delay_next[0] = tail_delay[1];
      tail_delay_next[1] = data_byte;
      for (int i = 0; i < 6; i++) begin
        if (kept_len == 8'(i + 1)) begin
          header_bytes_next[i] = data_byte;
        end
      end
      kept_len_next = kept_len + 8'd1;
    end
  end

  // Frame summary as seen after this byte.
  always_comb begin
    rx_crc = {tail_delay_next[1], tail_delay_next[0]};
    if (kept_len_next < MIN_FRAME_LEN) begin
      summary.status = ST_TOO_SHORT;
    end else if (rx_crc == crc_acc_next) begin
      summary.status = ST_OK;
    end else begin
      summary.status = ST_CRC_ERR;
    end
    summary.fn_code        = header_bytes_next[0];
    summary.byte_cnt_field = header_bytes_next[1];
    summary.b3             = header_bytes_next[2];
    summary.b4             = header_bytes_next[3];
    summary.b5             = header_bytes_next[4];
    summary.b6             = header_bytes_next[5];
    summary.length         = kept_len_next;
  end

  // State registers; the final byte clears them for the next frame.
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      crc_acc <= CRC_INIT;
      tail_delay[0] <= 8'd0;
      tail_delay[1] <= 8'd0;
      kept_len <= 8'd0;
      for (int i = 0; i < 6; i++) begin
        header_bytes[i] <= 8'd0;
      end
    end else if (step) begin
      crc_acc <= crc_acc_next;
      tail_delay <= tail_delay_next;
      kept_len <= kept_len_next;
      header_bytes <= header_bytes_next;
    end
  end

endmodule

`default_nettype wire

[hdl/modbus_rtu_response_check_decode_unit.sv]
// Top level of the Modbus RTU reply checker: input register, frame tracking, decode, result register.
`default_nettype none

// Takes one reply byte per transfer, the final byte marked by last_byte, and
// gives one result per frame: status (ok, too short, CRC mismatch), function
// code, decoded value and byte count. A byte is taken in every cycle unless a final
// byte waits for the result slot; the frame's result moves from the input register
// into the result register. The per-byte CRC-16 update, eight shift steps on the
// accumulator, is the longest path. Bytes past FRAME_CAPACITY are ignored, and
// the last decoded value is kept across frames for replies that do not update it.
module modbus_rtu_response_check_decode_unit
  import mrcd_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      byte_valid,
  output logic           byte_ready,
  input  wire mrcd_in_t  byte_item,
  output logic           result_valid,
  input  wire logic      result_ready,
  output mrcd_out_t      result
);

  logic            s0_valid;
  mrcd_in_t        s0_data;
  logic            out_free;
  logic            advance;
  logic            finish;
  mrcd_frame_sum_t summary;
  logic [31:0]     held_value;
  logic [31:0]     held_value_next;
  logic [1:0]      kind;
  mrcd_out_t       result_next;

  // Stage control: a non-final byte always moves on; a final one needs the result slot.
  assign out_free   = !result_valid || result_ready;
  assign advance    = s0_valid && (!s0_data.last_byte || out_free);
  assign finish     = advance && s0_data.last_byte;
  assign byte_ready = !s0_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (byte_ready) begin
      s0_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready) begin
      s0_data <= byte_item;
    end
  end

  mrcd_frame_track #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .data_byte(s0_data.rx_byte),
    .last     (s0_data.last_byte),
    .summary  (summary)
  );

  // Header decode.
  always_comb begin
    held_value_next = held_value;
    kind = KIND_UNSUPP;
    if (summary.fn_code == FC_READ_HOLDING) begin
      if (summary.byte_cnt_field == BC_ONE_WORD) begin
        held_value_next = {16'h0000, summary.b3, summary.b4};
        kind = KIND_WORD16;
      end else if (summary.byte_cnt_field == BC_TWO_WORD) begin
        held_value_next = {summary.b5, summary.b6, summary.b3, summary.b4};
        kind = KIND_WORD32;
      end else begin
        kind = KIND_KEEP;
      end
    end else if (summary.fn_code == FC_WRITE_SINGLE) begin
      held_value_next = {16'h0000, summary.b4, summary.b5};
      kind = KIND_WORD16;
    end else begin
      held_value_next = UNSUPPORTED_WORD;
      kind = KIND_UNSUPP;
    end
    result_next.status        = summary.status;
    result_next.fn_code       = summary.fn_code;
    result_next.decode_kind   = kind;
    result_next.value         = held_value_next;
    result_next.frame_length  = summary.length;
  end

  // Value held across frames.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_value <= 32'd0;
    end else if (finish) begin
      held_value <= held_value_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A final byte that moves on always produces a result in the next cycle.
  a_finish_gives_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> result_valid)
    else $error("final byte did not produce a result");

  // The status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_OK || result.status == ST_TOO_SHORT ||
                      result.status == ST_CRC_ERR))
    else $error("result status out of range");

  // An unchanged value only comes from a read reply.
  a_keep_only_read: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.decode_kind == KIND_KEEP) |->
      result.fn_code == FC_READ_HOLDING)
    else $error("value kept for a function other than read");

  // A passing CRC needs a frame long enough to carry one.
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_OK) |-> result.frame_length >= MIN_FRAME_LEN)
    else $error("ok status on a short frame");
`endif

endmodule

`default_nettype wire
